### design/crl_pkg.sv
// Shared constants and types for the countdown release list.
// No dependencies; imported by every module of the block except crl_ram.
package crl_pkg;

  // Default sizes of the entry table
  localparam int CAPACITY_DEF    = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed field widths of the words on both channels
  localparam int ID_W   = 16;
  localparam int TTL_W  = 16;
  localparam int PEND_W = 5;

  // Action codes of an input word
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DONE  = 5'b00100,
    S_EREAD = 5'b01000,
    S_EMIT  = 5'b10000
  } crl_state_t;

endpackage

### design/countdown_release_list_unit.sv
// Top level of the countdown release list: sequencer, entry table RAM and
// release buffer RAM. Depends on crl_pkg and crl_ram.
//
// Usage:
//   Input channel (item_valid/item_ready) carries one word: action selects an
//   add (entry_id, time_to_live appended at the back of the table) or a tick.
//   Output channel (result_valid/result_ready) carries result words. An add
//   gives one word (add_rejected set when the table was full). A tick gives
//   one word per released entry, in insertion order, last_result on the final
//   one, or a single word with released_valid low when nothing expired.
//   pending_total is the table occupancy after the whole input is applied.
// Timing:
//   item_ready is high only while the sequencer is idle; one word at a time.
//   Add: the result loads in S_DONE, once the output register is free.
//   Tick: S_SCAN visits every stored entry, then S_EREAD and S_EMIT give the
//   releases; an empty table or no release ends in S_DONE. The scan
//   is bound by the single read port of the entry table: one entry read,
//   decremented and written back (compacted) per cycle. Released identifiers
//   go to a release buffer RAM, read one word per cycle while output is free.
// Reset: rst clears the sequencer, occupancy and output valid. RAM contents
//   are not cleared; only entries below the occupancy are ever read.
// Stall: a result word is held in the output register until taken; the
//   sequencer waits on it and resumes as soon as the register frees.
module countdown_release_list_unit #(
  parameter int CAPACITY    = crl_pkg::CAPACITY_DEF,
  parameter int COUNT_WIDTH = crl_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic                       action,
  input  logic [crl_pkg::ID_W-1:0]   entry_id,
  input  logic [crl_pkg::TTL_W-1:0]  time_to_live,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic                       released_valid,
  output logic [crl_pkg::ID_W-1:0]   released_id,
  output logic                       last_result,
  output logic                       add_rejected,
  output logic [crl_pkg::PEND_W-1:0] pending_total
);
  import crl_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // table index
  localparam int OW = $clog2(CAPACITY + 1);                   // counts 0..CAPACITY
  localparam int EW = ID_W + COUNT_WIDTH;                     // {id, count}

  crl_state_t state;

  logic [OW-1:0] occ;        // entries held
  logic [OW-1:0] n_scan;     // entries to visit in this tick
  logic [OW-1:0] issued;     // reads issued
  logic [OW-1:0] proc_cnt;   // entries processed
  logic [OW-1:0] keep_cnt;   // entries kept (compaction write pointer)
  logic [OW-1:0] nrel;       // entries released
  logic [OW-1:0] ej;         // release buffer read pointer
  logic          dv;         // entry table read data valid
  logic          done_rej;   // add_rejected for a single-word result

  logic [COUNT_WIDTH-1:0] ttl_sat;
  logic [EW-1:0]          ent_q;
  logic [EW-1:0]          ent_wdata;
  logic [IW-1:0]          ent_waddr;
  logic                   ent_we;
  logic [ID_W-1:0]        id_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic                   expire;
  logic                   scan_issue;
  logic                   scan_last;
  logic                   full;
  logic                   add_go;
  logic                   out_free;
  logic                   load_out;
  logic [OW-1:0]          keep_next;
  logic [OW-1:0]          nrel_next;
  logic [OW-1:0]          ej_inc;
  logic                   emit_last;
  logic                   rel_we;
  logic                   rel_re;
  logic [IW-1:0]          rel_raddr;
  logic [ID_W-1:0]        rel_q;

  // Clamp the time to live into the stored count width
  if (COUNT_WIDTH < TTL_W) begin : g_sat
    assign ttl_sat = (|time_to_live[TTL_W-1:COUNT_WIDTH]) ? '1
                                                           : time_to_live[COUNT_WIDTH-1:0];
  end else begin : g_ext
    assign ttl_sat = COUNT_WIDTH'(time_to_live);
  end

  assign item_ready = (state == S_IDLE);
  assign out_free   = !result_valid || result_ready;
  assign load_out   = out_free && ((state == S_DONE) || (state == S_EMIT));
  assign full       = (occ == OW'(CAPACITY));
  assign add_go     = item_valid && item_ready && (action == ACT_ADD) && !full;

  // Entry read data split; a count of 0 or 1 expires on this tick
  assign id_q   = ent_q[EW-1:COUNT_WIDTH];
  assign cnt_q  = ent_q[COUNT_WIDTH-1:0];
  assign expire = (cnt_q <= COUNT_WIDTH'(1));

  assign scan_issue = (state == S_SCAN) && (issued < n_scan);
  assign scan_last  = (state == S_SCAN) && dv && ((proc_cnt + OW'(1)) == n_scan);
  assign keep_next  = keep_cnt + OW'(!expire);
  assign nrel_next  = nrel + OW'(expire);

  // Write port: append on add, write back kept entries during the scan.
  // The write pointer never passes the read pointer, so no forwarding.
  assign ent_we    = add_go || ((state == S_SCAN) && dv && !expire);
  assign ent_waddr = add_go ? occ[IW-1:0] : keep_cnt[IW-1:0];
  assign ent_wdata = add_go ? {entry_id, ttl_sat} : {id_q, cnt_q - COUNT_WIDTH'(1)};

  // Release buffer: fill during scan, drain afterwards
  assign ej_inc    = ej + OW'(1);
  assign emit_last = (ej_inc == nrel);
  assign rel_we    = (state == S_SCAN) && dv && expire;
  assign rel_re    = (state == S_EREAD) || ((state == S_EMIT) && out_free && !emit_last);
  assign rel_raddr = (state == S_EREAD) ? '0 : ej_inc[IW-1:0];

  crl_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (scan_issue),
    .raddr (issued[IW-1:0]),
    .rdata (ent_q)
  );

  crl_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_rel_ram (
    .clk   (clk),
    .we    (rel_we),
    .waddr (nrel[IW-1:0]),
    .wdata (id_q),
    .re    (rel_re),
    .raddr (rel_raddr),
    .rdata (rel_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      occ          <= '0;
      n_scan       <= '0;
      issued       <= '0;
      proc_cnt     <= '0;
      keep_cnt     <= '0;
      nrel         <= '0;
      ej           <= '0;
      dv           <= 1'b0;
      done_rej     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // Drop the output word once taken, unless a new word loads now
      if (result_valid && result_ready && !load_out) begin
        result_valid <= 1'b0;
      end
      dv <= scan_issue;
      if (scan_issue) begin
        issued <= issued + OW'(1);
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (action == ACT_ADD) begin
              if (!full) begin
                occ <= occ + OW'(1);
              end
              done_rej <= full;
              state    <= S_DONE;
            end else begin
              n_scan   <= occ;
              issued   <= '0;
              proc_cnt <= '0;
              keep_cnt <= '0;
              nrel     <= '0;
              done_rej <= 1'b0;
              state    <= (occ == '0) ? S_DONE : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (dv) begin
            proc_cnt <= proc_cnt + OW'(1);
            keep_cnt <= keep_next;
            nrel     <= nrel_next;
          end
          if (scan_last) begin
            occ   <= keep_next;
            state <= (nrel_next == '0) ? S_DONE : S_EREAD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            result_valid   <= 1'b1;
            released_valid <= 1'b0;
            released_id    <= '0;
            last_result    <= 1'b1;
            add_rejected   <= done_rej;
            pending_total  <= PEND_W'(occ);
            state          <= S_IDLE;
          end
        end
        S_EREAD: begin
          ej    <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            result_valid   <= 1'b1;
            released_valid <= 1'b1;
            released_id    <= rel_q;
            last_result    <= emit_last;
            add_rejected   <= 1'b0;
            pending_total  <= PEND_W'(occ);
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              ej <= ej_inc;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/crl_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No package dependency.
module crl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/crl_checker.sv
// Port-level checks for the countdown release list, bound to the top level.
// Depends on crl_pkg and countdown_release_list_unit.
module crl_checker #(
  parameter int CAPACITY = crl_pkg::CAPACITY_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_ready,
  input logic                       action,
  input logic [crl_pkg::ID_W-1:0]   entry_id,
  input logic [crl_pkg::TTL_W-1:0]  time_to_live,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic                       released_valid,
  input logic [crl_pkg::ID_W-1:0]   released_id,
  input logic                       last_result,
  input logic                       add_rejected,
  input logic [crl_pkg::PEND_W-1:0] pending_total
);
  import crl_pkg::*;

  // Hold an offered input word until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(action)
      && $stable(entry_id) && $stable(time_to_live))
    else $error("input word changed while waiting");

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(released_valid)
      && $stable(released_id) && $stable(last_result) && $stable(add_rejected)
      && $stable(pending_total))
    else $error("result word changed while stalled");

  // A word without a released entry is always the only word of its input
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !released_valid |-> last_result)
    else $error("non-release word not marked last");

  // A rejected add carries no entry and reports a full table
  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && add_rejected |-> !released_valid
      && (pending_total == PEND_W'(CAPACITY)))
    else $error("rejected add with release or table not full");

  // Occupancy never exceeds the table size
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(pending_total) <= 32'(CAPACITY)))
    else $error("pending total beyond capacity");

endmodule

bind countdown_release_list_unit crl_checker #(.CAPACITY(CAPACITY)) u_crl_checker (.*);

### dv/crl_release_checker.sv
// Checker for the countdown release list: watches both channels, keeps its own
// copy of the entry table and compares every result word. Depends on crl_pkg.
`timescale 1ns / 1ps

module crl_release_checker
  import crl_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  logic              action,
  input  logic [ID_W-1:0]   entry_id,
  input  logic [TTL_W-1:0]  time_to_live,
  input  logic              result_valid,
  input  logic              result_ready,
  input  logic              released_valid,
  input  logic [ID_W-1:0]   released_id,
  input  logic              last_result,
  input  logic              add_rejected,
  input  logic [PEND_W-1:0] pending_total,
  output int                mismatch_count,
  output int                words_owed
);

  localparam longint COUNT_MAX = (longint'(1) << COUNT_WIDTH) - 1;

  typedef struct packed {
    logic              rel_valid;
    logic [ID_W-1:0]   rel_id;
    logic              last;
    logic              rejected;
    logic [PEND_W-1:0] pend;
  } release_word_t;

  logic [ID_W-1:0] held_ids[CAPACITY];
  logic [31:0]     held_counts[CAPACITY];
  int              held_total = 0;
  release_word_t   owed_words[$];
  int              words_seen = 0;

  task automatic report_mismatch(input string field, input longint want, input longint got);
    $display("result %0d: %s expected %0h, got %0h", words_seen, field, want, got);
    mismatch_count++;
  endtask

  // Apply one accepted word to the table copy and queue the words it owes.
  task automatic advance_table(input logic act, input logic [ID_W-1:0] id,
                               input logic [TTL_W-1:0] ttl);
    release_word_t   w;
    logic [ID_W-1:0] gone[$];
    logic [31:0]     cnt;
    int              keep;
    w = '0;
    if (act == ACT_ADD) begin
      w.last     = 1'b1;
      w.rejected = (held_total >= CAPACITY);
      if (!w.rejected) begin
        cnt = 32'(ttl);
        if (longint'(cnt) > COUNT_MAX) cnt = COUNT_MAX[31:0];
        held_ids[held_total]    = id;
        held_counts[held_total] = cnt;
        held_total++;
      end
      w.pend = held_total[PEND_W-1:0];
      owed_words = {owed_words, w};
    end else begin
      keep = 0;
      // Release expired entries in order, compact the survivors.
      for (int i = 0; i < held_total; i++) begin
        if (held_counts[i] <= 1) begin
          gone = {gone, held_ids[i]};
        end else begin
          held_ids[keep]    = held_ids[i];
          held_counts[keep] = held_counts[i] - 1;
          keep++;
        end
      end
      held_total = keep;
      w.pend = held_total[PEND_W-1:0];
      if (gone.size() == 0) begin
        w.last = 1'b1;
        owed_words = {owed_words, w};
      end else begin
        foreach (gone[i]) begin
          w.rel_valid = 1'b1;
          w.rel_id    = gone[i];
          w.last      = (i == gone.size() - 1);
          owed_words = {owed_words, w};
        end
      end
    end
  endtask

  always @(posedge clk) begin
    release_word_t want;
    if (rst) begin
      held_total = 0;
      owed_words.delete();
    end else begin
      // Check the outgoing word first: it can never belong to a word taken now.
      if (result_valid && result_ready) begin
        if (owed_words.size() == 0) begin
          report_mismatch("word with nothing owed, released_id", 0, longint'(released_id));
        end else begin
          want = owed_words.pop_front();
          if (released_valid !== want.rel_valid)
            report_mismatch("released_valid", longint'(want.rel_valid),
                            longint'(released_valid));
          if (released_id !== want.rel_id)
            report_mismatch("released_id", longint'(want.rel_id), longint'(released_id));
          if (last_result !== want.last)
            report_mismatch("last_result", longint'(want.last), longint'(last_result));
          if (add_rejected !== want.rejected)
            report_mismatch("add_rejected", longint'(want.rejected),
                            longint'(add_rejected));
          if (pending_total !== want.pend)
            report_mismatch("pending_total", longint'(want.pend), longint'(pending_total));
        end
        words_seen++;
      end
      if (item_valid && item_ready) advance_table(action, entry_id, time_to_live);
    end
    words_owed = owed_words.size();
  end

endmodule

### dv/countdown_release_list_unit_tb.sv
// Testbench top for countdown_release_list_unit: drives add and tick words,
// stalls the result side, and reports the verdict of crl_release_checker.
`timescale 1ns / 1ps

module countdown_release_list_unit_tb;
  import crl_pkg::*;

  localparam int ITEM_TARGET = 400;
  localparam int HOLD_CYCLES = 80;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_ready;
  logic              action       = ACT_ADD;
  logic [ID_W-1:0]   entry_id     = '0;
  logic [TTL_W-1:0]  time_to_live = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic              released_valid;
  logic [ID_W-1:0]   released_id;
  logic              last_result;
  logic              add_rejected;
  logic [PEND_W-1:0] pending_total;

  int mismatch_count;
  int words_owed;
  int items_sent      = 0;
  int holds_requested = 0;
  bit steady_flow     = 1'b0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  countdown_release_list_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .action        (action),
    .entry_id      (entry_id),
    .time_to_live  (time_to_live),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .released_valid(released_valid),
    .released_id   (released_id),
    .last_result   (last_result),
    .add_rejected  (add_rejected),
    .pending_total (pending_total)
  );

  crl_release_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .action        (action),
    .entry_id      (entry_id),
    .time_to_live  (time_to_live),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .released_valid(released_valid),
    .released_id   (released_id),
    .last_result   (last_result),
    .add_rejected  (add_rejected),
    .pending_total (pending_total),
    .mismatch_count(mismatch_count),
    .words_owed    (words_owed)
  );

  // Offer one input word and return at the edge where it is taken. Valid stays
  // high afterwards, so call drop_valid before any pause that is not a send.
  task automatic send_word(input logic act, input logic [ID_W-1:0] id,
                           input logic [TTL_W-1:0] ttl);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid   = 1'b1;
    action       = act;
    entry_id     = id;
    time_to_live = ttl;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  task automatic add_entry(input logic [ID_W-1:0] id, input logic [TTL_W-1:0] ttl);
    send_word(ACT_ADD, id, ttl);
  endtask

  // Tick with random junk in the ignored fields.
  task automatic tick_once();
    send_word(ACT_TICK, ID_W'($urandom), TTL_W'($urandom));
  endtask

  // Mostly short lives so entries keep flowing out; a few linger longer.
  function automatic logic [TTL_W-1:0] draw_ttl();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return TTL_W'($urandom_range(0, 3));
    if (r < 9) return TTL_W'($urandom_range(4, 20));
    return TTL_W'($urandom_range(21, 60));
  endfunction

  task automatic mixed_word();
    if ($urandom_range(0, 2) == 0) tick_once();
    else add_entry(ID_W'($urandom), draw_ttl());
  endtask

  // Result side: draw a stall per word, or hold off for a long stretch when
  // the stimulus asks for it.
  initial begin
    int stall;
    int holds_done;
    holds_done = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (holds_done < holds_requested) begin
        holds_done++;
        result_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        stall = steady_flow ? 0 : $urandom_range(0, 4);
        if (stall > 0) begin
          result_ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      result_ready = 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    int pick;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Tick on an empty table: one word, nothing released.
    tick_once();

    // Fill to capacity with lives of zero and one, overflow once, then flush
    // all sixteen in a single tick.
    for (int k = 0; k < 16; k++) begin
      if (k == 0) add_entry(16'h0000, 16'h0000);
      else if (k == 1) add_entry(16'hFFFF, 16'h0001);
      else add_entry(ID_W'($urandom), TTL_W'(k % 2));
    end
    add_entry(16'h1234, 16'h0001);
    tick_once();

    // Widest life stays around for the rest of the run; the others expire.
    add_entry(16'hA5A5, 16'hFFFF);
    add_entry(16'h5A5A, 16'h0000);
    add_entry(16'h0F0F, 16'h0002);
    tick_once();
    tick_once();
    tick_once();

    // Hold the result side off while words keep coming, then pause the
    // sender until every owed word has come out.
    holds_requested++;
    repeat (8) mixed_word();
    drop_valid();
    while (words_owed != 0) @(negedge clk);

    // Random rounds
    while (items_sent < ITEM_TARGET) begin
      steady_flow = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        repeat ($urandom_range(4, 12)) mixed_word();
      end else if (pick < 8) begin
        // Fill toward or past capacity with short lives, then flush them with a tick.
        repeat ($urandom_range(12, 18))
          add_entry(ID_W'($urandom), TTL_W'($urandom_range(0, 1)));
        tick_once();
      end else if (pick == 8) begin
        // Hold the result side off and keep offering so the input stalls.
        holds_requested++;
        repeat (8) mixed_word();
      end else begin
        // Pause the sender until every owed word has come out.
        drop_valid();
        while (words_owed != 0) @(negedge clk);
        mixed_word();
      end
    end

    drop_valid();
    while (words_owed != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && words_owed == 0) begin
      $display("countdown_release_list_unit regression: pass");
    end else begin
      $display("countdown_release_list_unit regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("countdown_release_list_unit regression: fail");
    $finish;
  end

endmodule

### files.f
design/crl_pkg.sv
design/crl_ram.sv
design/countdown_release_list_unit.sv
design/crl_checker.sv
dv/crl_release_checker.sv
dv/countdown_release_list_unit_tb.sv
